// ----- design/c6502_pkg.sv -----
// Shared types and opcode codes for the 6502 execute unit.
// No dependencies.
package c6502_pkg;

	localparam int StackDepthDefault = 256;

	localparam logic [7:0] FlagC = 8'h01;
	localparam logic [7:0] FlagZ = 8'h02;
	localparam logic [7:0] FlagI = 8'h04;
	localparam logic [7:0] FlagD = 8'h08;
	localparam logic [7:0] FlagB = 8'h10;
	localparam logic [7:0] FlagU = 8'h20;
	localparam logic [7:0] FlagV = 8'h40;
	localparam logic [7:0] FlagN = 8'h80;
	localparam logic [7:0] SpReset = 8'hFD;
	localparam logic [7:0] StatusReset = 8'b00000100;

	typedef enum logic [1:0] {
		REG_RESET_VEC = 2'd0,
		REG_NMI_VEC   = 2'd1,
		REG_IRQ_VEC   = 2'd2
	} reg_idx_t;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
		OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
		OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
		OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
		OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
		OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
		OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
		OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
		OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
		OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
		OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
		OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
		OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
		OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55,
		OP_NMI = 6'd56, OP_IRQ = 6'd57
	} op_t;

	// architectural registers
	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
	} regs_t;

	// stack write request: count of bytes pushed and bytes in push order
	typedef struct packed {
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} push_t;

	// bytes above the stack pointer, nearest first
	typedef struct packed {
		logic [7:0] r0;
		logic [7:0] r1;
		logic [7:0] r2;
	} pull_t;

	function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
		logic [7:0] q;
		q = p & ~(FlagZ | FlagN);
		if (v == 8'h00) q = q | FlagZ;
		return q | (v & FlagN);
	endfunction

endpackage

// ----- design/cpu_6502_execute_unit_core.sv -----
// Top level of the 6502 execute unit: request/result handshakes and registers.
// Depends on c6502_pkg, c6502_exec and c6502_stack.
//
// Executes one decoded 6502 instruction per cycle while neither the output stall
// nor the stack sweep holds it. A request is captured in an input register,
// executed through the single combinational execute path against the architectural
// registers and stack page, and the outcome lands in a result register; a new
// request can be taken every cycle while results flow out. Throughput is one per
// cycle, bounded by the output stall and the stack sweep. After reset the stack
// page is swept to 0xFF four bytes a cycle; the input stalls during the sweep,
// configuration writes are taken.
// STACK_DEPTH must be a power of two. Writing the reset vector also loads PC;
// write configuration only while no request is in flight.
module cpu_6502_execute_unit_core #(
	parameter int STACK_DEPTH = c6502_pkg::StackDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  op,
	input  logic [7:0]  operand,
	input  logic [15:0] target_address,
	input  logic [1:0]  instr_length,
	input  logic        acc_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        mem_write,
	output logic [7:0]  write_data,
	output logic [15:0] pc_next,
	output logic [7:0]  acc_out,
	output logic [7:0]  x_out,
	output logic [7:0]  y_out,
	output logic [7:0]  sp_out,
	output logic [7:0]  status_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import c6502_pkg::*;

	logic        valid_s1;
	logic [5:0]  op_s1;
	logic [7:0]  operand_s1;
	logic [15:0] target_s1;
	logic [1:0]  len_s1;
	logic        accm_s1;
	logic        advance;
	logic        exec_we;
	logic        stack_busy;
	logic [7:0]  sp_nxt;
	regs_t       regs_q, regs_nxt;
	push_t       push;
	pull_t       pull;
	logic [15:0] nmi_vec_q, irq_vec_q;
	logic        wr_nxt;
	logic [7:0]  wd_nxt;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = stack_busy || (valid_s1 && !advance);
	assign exec_we  = advance && !cfg_we;
	assign sp_nxt   = exec_we ? regs_nxt.sp : regs_q.sp;

	// capture requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1      <= op;
			operand_s1 <= operand;
			target_s1  <= target_address;
			len_s1     <= instr_length;
			accm_s1    <= acc_mode;
		end
	end

	c6502_exec u_exec (
		.op             (op_s1),
		.operand        (operand_s1),
		.target_address (target_s1),
		.instr_length   (len_s1),
		.acc_mode       (accm_s1),
		.cur            (regs_q),
		.nmi_vec        (nmi_vec_q),
		.irq_vec        (irq_vec_q),
		.pull           (pull),
		.nxt            (regs_nxt),
		.push           (push),
		.mem_write      (wr_nxt),
		.write_data     (wd_nxt)
	);

	c6502_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (exec_we),
		.sp     (regs_q.sp),
		.sp_nxt (sp_nxt),
		.push   (push),
		.pull   (pull),
		.busy   (stack_busy)
	);

	// architectural registers and vector configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q      <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SpReset,
			                 p: StatusReset, pc: 16'h0000};
			nmi_vec_q   <= 16'h0000;
			irq_vec_q   <= 16'h0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESET_VEC: regs_q.pc <= cfg_data;
				REG_NMI_VEC:   nmi_vec_q <= cfg_data;
				REG_IRQ_VEC:   irq_vec_q <= cfg_data;
				default: ;
			endcase
		end else if (advance) begin
			regs_q <= regs_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mem_write  <= wr_nxt;
			write_data <= wd_nxt;
			pc_next    <= regs_nxt.pc;
			acc_out    <= regs_nxt.a;
			x_out      <= regs_nxt.x;
			y_out      <= regs_nxt.y;
			sp_out     <= regs_nxt.sp;
			status_out <= regs_nxt.p;
		end
	end

	// input side stalls only during the sweep or behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (stack_busy || (valid_s1 && out_valid && out_stall)))
		else $error("input stalled without a held result");

	// a held result keeps its program counter
	a_hold_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pc_next)))
		else $error("held result changed");

	// registers move only on execution or configuration
	a_regs_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(advance) && !$past(cfg_we)) |-> $stable(regs_q))
		else $error("registers changed while idle");

endmodule

// ----- design/c6502_stack.sv -----
// Stack page storage: four banks by slot, up to three pushes and three pulled bytes per instruction.
// Depends on c6502_pkg.
module c6502_stack #(
	parameter int STACK_DEPTH = c6502_pkg::StackDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [7:0]        sp,
	input  logic [7:0]        sp_nxt,
	input  c6502_pkg::push_t  push,
	output c6502_pkg::pull_t  pull,
	output logic              busy
);
	import c6502_pkg::*;

	// depth is a power of two; consecutive slots fall in different banks
	localparam int BANK_DEPTH = STACK_DEPTH / 4;
	localparam int RW = $clog2(BANK_DEPTH);
	localparam logic [RW-1:0] LAST_ROW = RW'(BANK_DEPTH - 1);

	logic [RW-1:0] clr_row_q;
	logic          clr_busy_q;
	logic [7:0]    rd_data [4];
	logic [7:0]    sp_p1, sp_p2, sp_p3;

	always_comb begin
		sp_p1 = sp + 8'd1;
		sp_p2 = sp + 8'd2;
		sp_p3 = sp + 8'd3;
	end

	// pick the bytes a pull would take from the bank holding each slot
	assign pull.r0 = rd_data[sp_p1[1:0]];
	assign pull.r1 = rd_data[sp_p2[1:0]];
	assign pull.r2 = rd_data[sp_p3[1:0]];

	// sweep every row to 0xFF after reset, one row of all banks per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_row_q == LAST_ROW) clr_busy_q <= 1'b0;
			clr_row_q <= clr_row_q + RW'(1);
		end
	end

	assign busy = clr_busy_q;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0]    mem_q [BANK_DEPTH];
		logic [7:0]    rd_q;
		logic [1:0]    push_k, pull_k;
		logic [7:0]    wr_slot, rd_slot;
		logic          wr_en;
		logic [RW-1:0] wr_row, rd_row;
		logic [7:0]    wr_byte;

		// map the pushed byte and the next pulled slot onto this bank
		always_comb begin
			push_k  = sp[1:0] - 2'(b);
			pull_k  = 2'(b) - sp_nxt[1:0] - 2'd1;
			wr_slot = sp - {6'd0, push_k};
			rd_slot = sp_nxt + 8'd1 + {6'd0, pull_k};
			wr_row  = wr_slot[RW+1:2];
			rd_row  = rd_slot[RW+1:2];
			unique case (push_k)
				2'd0:    wr_byte = push.b0;
				2'd1:    wr_byte = push.b1;
				default: wr_byte = push.b2;
			endcase
			wr_en = we && (push_k < push.n);
			if (clr_busy_q) begin
				wr_en   = 1'b1;
				wr_row  = clr_row_q;
				wr_byte = 8'hFF;
			end
		end

		// write the bank and register the read, passing a same-row write through
		always_ff @(posedge clk) begin
			if (wr_en) mem_q[wr_row] <= wr_byte;
			if (wr_en && wr_row == rd_row) rd_q <= wr_byte;
			else rd_q <= mem_q[rd_row];
		end

		assign rd_data[b] = rd_q;
	end

endmodule

// ----- design/c6502_exec.sv -----
// Combinational instruction execution: ALU, flags, branches, stack traffic.
// Depends on c6502_pkg.
module c6502_exec (
	input  logic [5:0]         op,
	input  logic [7:0]         operand,
	input  logic [15:0]        target_address,
	input  logic [1:0]         instr_length,
	input  logic               acc_mode,
	input  c6502_pkg::regs_t   cur,
	input  logic [15:0]        nmi_vec,
	input  logic [15:0]        irq_vec,
	input  c6502_pkg::pull_t   pull,
	output c6502_pkg::regs_t   nxt,
	output c6502_pkg::push_t   push,
	output logic               mem_write,
	output logic [7:0]         write_data
);
	import c6502_pkg::*;

	logic [15:0] seq_pc, taken_pc, pc_ret;
	logic [8:0]  sum;
	logic [7:0]  addend, src, sh, res8, cmp_reg;
	logic        sh_c;

	always_comb begin
		seq_pc   = cur.pc + {14'd0, instr_length};
		taken_pc = seq_pc + {{8{operand[7]}}, operand};
		pc_ret   = cur.pc + 16'd2;
		addend   = (op == OP_SBC) ? ~operand : operand;
		sum      = {1'b0, cur.a} + {1'b0, addend} + {8'd0, cur.p[0]};
		src      = acc_mode ? cur.a : operand;
		cmp_reg  = (op == OP_CPX) ? cur.x : ((op == OP_CPY) ? cur.y : cur.a);
		res8     = cmp_reg - operand;
		unique case (op)
			OP_ASL:  begin sh = {src[6:0], 1'b0};     sh_c = src[7]; end
			OP_ROL:  begin sh = {src[6:0], cur.p[0]}; sh_c = src[7]; end
			OP_LSR:  begin sh = {1'b0, src[7:1]};     sh_c = src[0]; end
			default: begin sh = {cur.p[0], src[7:1]}; sh_c = src[0]; end
		endcase
	end

	// decode and execute one instruction
	always_comb begin
		nxt        = cur;
		nxt.pc     = seq_pc;
		push       = '0;
		mem_write  = 1'b0;
		write_data = 8'h00;
		unique case (op)
			OP_ADC, OP_SBC: begin
				nxt.a = sum[7:0];
				nxt.p = with_nz(cur.p & ~(FlagC | FlagV), sum[7:0]);
				nxt.p[0] = sum[8];
				nxt.p[6] = ~(cur.a[7] ^ addend[7]) & (cur.a[7] ^ sum[7]);
			end
			OP_AND: begin nxt.a = cur.a & operand; nxt.p = with_nz(cur.p, nxt.a); end
			OP_EOR: begin nxt.a = cur.a ^ operand; nxt.p = with_nz(cur.p, nxt.a); end
			OP_ORA: begin nxt.a = cur.a | operand; nxt.p = with_nz(cur.p, nxt.a); end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				nxt.p = with_nz(cur.p, sh);
				nxt.p[0] = sh_c;
				if (acc_mode) begin
					nxt.a = sh;
				end else begin
					mem_write  = 1'b1;
					write_data = sh;
				end
			end
			OP_BCC: if (!cur.p[0]) nxt.pc = taken_pc;
			OP_BCS: if (cur.p[0])  nxt.pc = taken_pc;
			OP_BEQ: if (cur.p[1])  nxt.pc = taken_pc;
			OP_BNE: if (!cur.p[1]) nxt.pc = taken_pc;
			OP_BMI: if (cur.p[7])  nxt.pc = taken_pc;
			OP_BPL: if (!cur.p[7]) nxt.pc = taken_pc;
			OP_BVS: if (cur.p[6])  nxt.pc = taken_pc;
			OP_BVC: if (!cur.p[6]) nxt.pc = taken_pc;
			OP_BIT: begin
				nxt.p = (cur.p & ~(FlagZ | FlagV | FlagN)) | (operand & (FlagV | FlagN));
				nxt.p[1] = ((cur.a & operand) == 8'h00);
			end
			OP_BRK: begin
				push   = '{n: 2'd3, b0: pc_ret[15:8], b1: pc_ret[7:0],
				           b2: cur.p | FlagB | FlagU};
				nxt.sp = cur.sp - 8'd3;
				nxt.p  = cur.p | FlagB | FlagU | FlagI;
				nxt.pc = irq_vec;
			end
			OP_CLC: nxt.p = cur.p & ~FlagC;
			OP_CLD: nxt.p = cur.p & ~FlagD;
			OP_CLI: nxt.p = cur.p & ~FlagI;
			OP_CLV: nxt.p = cur.p & ~FlagV;
			OP_SEC: nxt.p = cur.p | FlagC;
			OP_SED: nxt.p = cur.p | FlagD;
			OP_SEI: nxt.p = cur.p | FlagI;
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.p = with_nz(cur.p, res8);
				nxt.p[0] = (cmp_reg >= operand);
			end
			OP_DEC: begin
				mem_write = 1'b1; write_data = operand - 8'd1;
				nxt.p = with_nz(cur.p, write_data);
			end
			OP_INC: begin
				mem_write = 1'b1; write_data = operand + 8'd1;
				nxt.p = with_nz(cur.p, write_data);
			end
			OP_DEX: begin nxt.x = cur.x - 8'd1; nxt.p = with_nz(cur.p, nxt.x); end
			OP_DEY: begin nxt.y = cur.y - 8'd1; nxt.p = with_nz(cur.p, nxt.y); end
			OP_INX: begin nxt.x = cur.x + 8'd1; nxt.p = with_nz(cur.p, nxt.x); end
			OP_INY: begin nxt.y = cur.y + 8'd1; nxt.p = with_nz(cur.p, nxt.y); end
			OP_JMP: nxt.pc = target_address;
			OP_JSR: begin
				push   = '{n: 2'd2, b0: pc_ret[15:8], b1: pc_ret[7:0], b2: 8'h00};
				nxt.sp = cur.sp - 8'd2;
				nxt.pc = target_address;
			end
			OP_LDA: begin nxt.a = operand; nxt.p = with_nz(cur.p, operand); end
			OP_LDX: begin nxt.x = operand; nxt.p = with_nz(cur.p, operand); end
			OP_LDY: begin nxt.y = operand; nxt.p = with_nz(cur.p, operand); end
			OP_PHA: begin
				push   = '{n: 2'd1, b0: cur.a, b1: 8'h00, b2: 8'h00};
				nxt.sp = cur.sp - 8'd1;
			end
			OP_PHP: begin
				push   = '{n: 2'd1, b0: cur.p | FlagB | FlagU, b1: 8'h00, b2: 8'h00};
				nxt.sp = cur.sp - 8'd1;
			end
			OP_PLA: begin
				nxt.a  = pull.r0; nxt.p = with_nz(cur.p, pull.r0);
				nxt.sp = cur.sp + 8'd1;
			end
			OP_PLP: begin
				nxt.p  = (cur.p & (FlagB | FlagU)) | (pull.r0 & ~(FlagB | FlagU));
				nxt.sp = cur.sp + 8'd1;
			end
			OP_RTI: begin
				nxt.p  = (cur.p & (FlagB | FlagU)) | (pull.r0 & ~(FlagB | FlagU));
				nxt.pc = {pull.r2, pull.r1};
				nxt.sp = cur.sp + 8'd3;
			end
			OP_RTS: begin
				nxt.pc = {pull.r1, pull.r0} + 16'd1;
				nxt.sp = cur.sp + 8'd2;
			end
			OP_STA: begin mem_write = 1'b1; write_data = cur.a; end
			OP_STX: begin mem_write = 1'b1; write_data = cur.x; end
			OP_STY: begin mem_write = 1'b1; write_data = cur.y; end
			OP_TAX: begin nxt.x = cur.a;  nxt.p = with_nz(cur.p, cur.a); end
			OP_TAY: begin nxt.y = cur.a;  nxt.p = with_nz(cur.p, cur.a); end
			OP_TSX: begin nxt.x = cur.sp; nxt.p = with_nz(cur.p, cur.sp); end
			OP_TXA: begin nxt.a = cur.x;  nxt.p = with_nz(cur.p, cur.x); end
			OP_TXS: nxt.sp = cur.x;
			OP_TYA: begin nxt.a = cur.y;  nxt.p = with_nz(cur.p, cur.y); end
			OP_NMI, OP_IRQ: begin
				if (op == OP_IRQ && cur.p[2]) begin
					nxt.pc = cur.pc;
				end else begin
					push   = '{n: 2'd3, b0: cur.pc[15:8], b1: cur.pc[7:0],
					           b2: (cur.p & ~FlagB) | FlagU};
					nxt.sp = cur.sp - 8'd3;
					nxt.p  = (cur.p & ~FlagB) | FlagU | FlagI;
					nxt.pc = (op == OP_NMI) ? nmi_vec : irq_vec;
				end
			end
			default: ;
		endcase
	end

endmodule
